// ===== design/cso_pkg.sv =====
package cso_pkg;

  localparam int MAX_DIM_DEF = 4096;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_COLOR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y     = 3'd4;

  localparam logic [12:0] FRAME_DIM_RST = 13'd4096;

  localparam int QUEUE_DEPTH = 4;
  localparam int NUM_W = 17;
  localparam int CHANNELS = 3;

  localparam logic [15:0] RECIP255_16 = 16'h8081;
  localparam logic [24:0] RECIP255_24 = 25'h0101_0102;

  typedef struct packed {
    logic        keep;
    logic [23:0] pixel_index;
    logic [15:0] cov_op;
    logic [7:0]  dest_red;
    logic [7:0]  dest_green;
    logic [7:0]  dest_blue;
    logic [7:0]  dest_alpha;
  } cso_item_t;

  function automatic logic [7:0] div255_16(input logic [15:0] x);
    logic [31:0] p;
    p = 32'(x) * 32'(RECIP255_16);
    return p[30:23];
  endfunction

  function automatic logic [15:0] div255_24(input logic [23:0] x);
    logic [48:0] p;
    p = 49'(x) * 49'(RECIP255_24);
    return p[47:32];
  endfunction

endpackage

// ===== design/cso_front.sv =====
module cso_front #(
  parameter int MAX_DIM = cso_pkg::MAX_DIM_DEF
) (
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_coverage,
  input  logic [11:0]        in_image_col,
  input  logic [11:0]        in_image_row,
  input  logic [7:0]         in_dest_red,
  input  logic [7:0]         in_dest_green,
  input  logic [7:0]         in_dest_blue,
  input  logic [7:0]         in_dest_alpha,
  input  logic [31:0]        source_color,
  input  logic [12:0]        frame_width,
  input  logic [12:0]        frame_height,
  input  logic signed [12:0] origin_x,
  input  logic signed [12:0] origin_y,
  output logic               push_valid,
  input  logic               push_ready,
  output cso_pkg::cso_item_t push_item
);
  import cso_pkg::*;

  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int CMP_W = (DIM_W > 13) ? DIM_W : 13;

  logic signed [13:0] fx;
  logic signed [13:0] fy;
  logic [CMP_W-1:0]   fw_c;
  logic [CMP_W-1:0]   fh_c;
  logic               in_frame;
  logic [7:0]         opacity;

  always_comb begin
    fx = 14'(origin_x) + signed'(14'(in_image_col));
    fy = 14'(origin_y) + signed'(14'(in_image_row));
    fw_c = (CMP_W'(frame_width) > CMP_W'(MAX_DIM)) ? CMP_W'(MAX_DIM) : CMP_W'(frame_width);
    fh_c = (CMP_W'(frame_height) > CMP_W'(MAX_DIM)) ? CMP_W'(MAX_DIM) : CMP_W'(frame_height);
    in_frame = !fx[13] && !fy[13] &&
               (CMP_W'(fx[12:0]) < fw_c) && (CMP_W'(fy[12:0]) < fh_c);
    opacity = 8'hFF - source_color[7:0];

    push_item.keep        = in_frame && (in_coverage != 8'd0);
    push_item.pixel_index = 24'(fy[12:0]) * 24'(fw_c) + 24'(fx[12:0]);
    push_item.cov_op      = 16'(in_coverage) * 16'(opacity);
    push_item.dest_red    = in_dest_red;
    push_item.dest_green  = in_dest_green;
    push_item.dest_blue   = in_dest_blue;
    push_item.dest_alpha  = in_dest_alpha;
  end

  assign push_valid = in_valid;
  assign in_ready   = push_ready;

endmodule

// ===== design/cso_queue.sv =====
module cso_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  output logic               push_ready,
  input  cso_pkg::cso_item_t push_item,
  output logic               pop_valid,
  input  logic               pop_ready,
  output cso_pkg::cso_item_t pop_item
);
  import cso_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cso_item_t        mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             push;
  logic             pop;

  assign push_ready = (count_r != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== design/cso_div.sv =====
module cso_div (
  input  logic                      clk,
  input  logic                      en,
  input  logic [cso_pkg::NUM_W-1:0] num,
  input  logic [7:0]                den,
  output logic [cso_pkg::NUM_W-1:0] quo
);
  import cso_pkg::*;

  logic [7:0]       rem_r [NUM_W];
  logic [7:0]       den_r [NUM_W];
  logic [NUM_W-1:0] num_r [NUM_W];
  logic [NUM_W-1:0] quo_r [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic [7:0]       rem_in;
    logic [7:0]       den_in;
    logic [NUM_W-1:0] num_in;
    logic [NUM_W-1:0] quo_in;
    logic [8:0]       trial;
    logic             ge;
    logic [7:0]       rem_nxt;
    logic [NUM_W-1:0] quo_nxt;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign den_in = den;
      assign num_in = num;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign den_in = den_r[k-1];
      assign num_in = num_r[k-1];
      assign quo_in = quo_r[k-1];
    end

    always_comb begin
      trial   = {rem_in, num_in[NUM_W-1-k]};
      ge      = (trial >= {1'b0, den_in});
      rem_nxt = ge ? 8'(trial - {1'b0, den_in}) : trial[7:0];
      quo_nxt = quo_in;
      quo_nxt[NUM_W-1-k] = ge;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        den_r[k] <= den_in;
        num_r[k] <= num_in;
        quo_r[k] <= quo_nxt;
      end
    end
  end

  assign quo = quo_r[NUM_W-1];

endmodule

// ===== design/cso_blend.sv =====
module cso_blend (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  cso_pkg::cso_item_t pop_item,
  input  logic [31:0]        source_color,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_write_enable,
  output logic [23:0]        out_pixel_index,
  output logic [7:0]         out_red,
  output logic [7:0]         out_green,
  output logic [7:0]         out_blue,
  output logic [7:0]         out_alpha
);
  import cso_pkg::*;

  logic adv;
  logic [4:0] sv_r;

  logic [7:0]  a1_r, da1_r;
  logic        keep1_r;
  logic [23:0] idx1_r;
  logic [7:0]  dst1_r [CHANNELS];

  logic [7:0]  a2_r;
  logic        keep2_r;
  logic [23:0] idx2_r;
  logic [15:0] t2_r;
  logic [15:0] sa2_r [CHANNELS];
  logic [7:0]  dst2_r [CHANNELS];

  logic [7:0]  a3_r, t3_r;
  logic        keep3_r;
  logic [23:0] idx3_r;
  logic [15:0] sa3_r [CHANNELS];
  logic [23:0] dt3_r [CHANNELS];

  logic [7:0]  a4_r, o4_r;
  logic        keep4_r;
  logic [23:0] idx4_r;
  logic [15:0] sa4_r [CHANNELS];
  logic [15:0] dd4_r [CHANNELS];

  logic [7:0]       o5_r;
  logic             we5_r;
  logic [23:0]      idx5_r;
  logic [NUM_W-1:0] num5_r [CHANNELS];

  logic        dv_r   [NUM_W];
  logic        dwe_r  [NUM_W];
  logic [23:0] didx_r [NUM_W];
  logic [7:0]  do_r   [NUM_W];

  logic [NUM_W-1:0] quo [CHANNELS];
  logic [7:0]       src [CHANNELS];
  logic [7:0]       sat [CHANNELS];

  logic        out_valid_r;
  logic        out_we_r;
  logic [23:0] out_idx_r;
  logic [7:0]  out_col_r [CHANNELS];
  logic [7:0]  out_alpha_r;

  assign adv       = !out_valid_r || out_ready;
  assign pop_ready = adv;

  assign src[0] = source_color[31:24];
  assign src[1] = source_color[23:16];
  assign src[2] = source_color[15:8];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r        <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_W; i++) begin
        dv_r[i] <= 1'b0;
      end
    end else if (adv) begin
      sv_r        <= {sv_r[3:0], pop_valid};
      dv_r[0]     <= sv_r[4];
      for (int i = 1; i < NUM_W; i++) begin
        dv_r[i] <= dv_r[i-1];
      end
      out_valid_r <= dv_r[NUM_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a1_r    <= div255_16(pop_item.cov_op);
      da1_r   <= pop_item.dest_alpha;
      keep1_r <= pop_item.keep;
      idx1_r  <= pop_item.pixel_index;
      dst1_r[0] <= pop_item.dest_red;
      dst1_r[1] <= pop_item.dest_green;
      dst1_r[2] <= pop_item.dest_blue;

      a2_r    <= a1_r;
      keep2_r <= keep1_r;
      idx2_r  <= idx1_r;
      t2_r    <= 16'(da1_r) * 16'(8'hFF - a1_r);

      a3_r    <= a2_r;
      keep3_r <= keep2_r;
      idx3_r  <= idx2_r;
      t3_r    <= div255_16(t2_r);

      a4_r    <= a3_r;
      keep4_r <= keep3_r;
      idx4_r  <= idx3_r;
      o4_r    <= 8'(9'(a3_r) + 9'(t3_r));

      o5_r    <= o4_r;
      we5_r   <= keep4_r && (a4_r != 8'd0) && (o4_r != 8'd0);
      idx5_r  <= idx4_r;

      for (int c = 0; c < CHANNELS; c++) begin
        dst2_r[c] <= dst1_r[c];
        sa2_r[c]  <= 16'(src[c]) * 16'(a1_r);
        sa3_r[c]  <= sa2_r[c];
        dt3_r[c]  <= 24'(dst2_r[c]) * 24'(t2_r);
        sa4_r[c]  <= sa3_r[c];
        dd4_r[c]  <= div255_24(dt3_r[c]);
        num5_r[c] <= NUM_W'(sa4_r[c]) + NUM_W'(dd4_r[c]);
      end

      dwe_r[0]  <= we5_r;
      didx_r[0] <= idx5_r;
      do_r[0]   <= o5_r;
      for (int i = 1; i < NUM_W; i++) begin
        dwe_r[i]  <= dwe_r[i-1];
        didx_r[i] <= didx_r[i-1];
        do_r[i]   <= do_r[i-1];
      end

      out_we_r    <= dwe_r[NUM_W-1];
      out_idx_r   <= dwe_r[NUM_W-1] ? didx_r[NUM_W-1] : 24'd0;
      out_alpha_r <= dwe_r[NUM_W-1] ? do_r[NUM_W-1] : 8'd0;
      for (int c = 0; c < CHANNELS; c++) begin
        out_col_r[c] <= dwe_r[NUM_W-1] ? sat[c] : 8'd0;
      end
    end
  end

  for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
    cso_div u_div (
      .clk (clk),
      .en  (adv),
      .num (num5_r[c]),
      .den (o5_r),
      .quo (quo[c])
    );

    assign sat[c] = (quo[c][NUM_W-1:8] != '0) ? 8'hFF : quo[c][7:0];
  end

  assign out_valid        = out_valid_r;
  assign out_write_enable = out_we_r;
  assign out_pixel_index  = out_idx_r;
  assign out_red          = out_col_r[0];
  assign out_green        = out_col_r[1];
  assign out_blue         = out_col_r[2];
  assign out_alpha        = out_alpha_r;

endmodule

// ===== design/coverage_source_over_blend_core.sv =====
// Coverage-scaled source-over blend of one solid colour onto an RGBA frame.
// Input channel (in_*): one coverage sample at an image position together
// with the destination pixel under it; one transfer per clock when ready.
// Result channel (out_*): one result per input, in order: write flag, frame
// pixel index and blended RGBA. Fields other than the flag read zero when
// the pixel is clipped or fully transparent.
// Configuration port (cfg_*): index 0 colour, 1 width, 2 height, 3 origin x,
// 4 origin y; write only while no transfer is in flight.
// Throughput: one item per clock unless stalled; the front classifies and
// indexes in the accepting cycle, a four-entry queue decouples it from the
// blend pipeline. Path from input transfer to result valid: the queue, five
// scaling and /255 stages, the one-bit-per-stage divider by the result alpha
// and the output register.
// When the receiver stalls the blend pipeline holds; the queue keeps
// accepting until full, then in_ready falls.
// Reset (synchronous, active low) empties queue and pipeline and restores
// colour 0, a 4096 x 4096 frame and origin 0.
module coverage_source_over_blend_core #(
  parameter int MAX_DIM = cso_pkg::MAX_DIM_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_coverage,
  input  logic [11:0]                    in_image_col,
  input  logic [11:0]                    in_image_row,
  input  logic [7:0]                     in_dest_red,
  input  logic [7:0]                     in_dest_green,
  input  logic [7:0]                     in_dest_blue,
  input  logic [7:0]                     in_dest_alpha,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_write_enable,
  output logic [23:0]                    out_pixel_index,
  output logic [7:0]                     out_red,
  output logic [7:0]                     out_green,
  output logic [7:0]                     out_blue,
  output logic [7:0]                     out_alpha,
  input  logic                           cfg_write_enable,
  input  logic [cso_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cso_pkg::CFG_DATA_W-1:0] cfg_data
);
  import cso_pkg::*;

  logic [31:0]        source_color_r;
  logic [12:0]        frame_width_r;
  logic [12:0]        frame_height_r;
  logic signed [12:0] origin_x_r;
  logic signed [12:0] origin_y_r;

  logic      push_valid;
  logic      push_ready;
  cso_item_t push_item;
  logic      pop_valid;
  logic      pop_ready;
  cso_item_t pop_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      source_color_r <= '0;
      frame_width_r  <= FRAME_DIM_RST;
      frame_height_r <= FRAME_DIM_RST;
      origin_x_r     <= '0;
      origin_y_r     <= '0;
    end else if (cfg_write_enable) begin
      case (cfg_index)
        CFG_SOURCE_COLOR: source_color_r <= cfg_data[31:0];
        CFG_FRAME_WIDTH:  frame_width_r  <= cfg_data[12:0];
        CFG_FRAME_HEIGHT: frame_height_r <= cfg_data[12:0];
        CFG_ORIGIN_X:     origin_x_r     <= signed'(cfg_data[12:0]);
        CFG_ORIGIN_Y:     origin_y_r     <= signed'(cfg_data[12:0]);
        default: ;
      endcase
    end
  end

  cso_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_coverage   (in_coverage),
    .in_image_col  (in_image_col),
    .in_image_row  (in_image_row),
    .in_dest_red   (in_dest_red),
    .in_dest_green (in_dest_green),
    .in_dest_blue  (in_dest_blue),
    .in_dest_alpha (in_dest_alpha),
    .source_color  (source_color_r),
    .frame_width   (frame_width_r),
    .frame_height  (frame_height_r),
    .origin_x      (origin_x_r),
    .origin_y      (origin_y_r),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_item     (push_item)
  );

  cso_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  cso_blend u_blend (
    .clk              (clk),
    .rst_n            (rst_n),
    .pop_valid        (pop_valid),
    .pop_ready        (pop_ready),
    .pop_item         (pop_item),
    .source_color     (source_color_r),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_write_enable (out_write_enable),
    .out_pixel_index  (out_pixel_index),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_alpha        (out_alpha)
  );

endmodule

// ===== verif/coverage_source_over_blend_core_tb.sv =====
`timescale 1ns / 1ps

module coverage_source_over_blend_core_tb;
  import cso_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DIM_CAP = 4096;
  localparam int DRAIN_CYCLES = 40;
  localparam int LONG_HOLD = 120;
  localparam int PHASES = 12;
  localparam int PHASE_PIXELS = 100;

  typedef struct packed {
    logic [7:0]  cov;
    logic [11:0] col;
    logic [11:0] row;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
  } pixel_t;

  typedef struct packed {
    logic        we;
    logic [23:0] index;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
  } blend_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] in_coverage = '0;
  logic [11:0] in_image_col = '0;
  logic [11:0] in_image_row = '0;
  logic [7:0] in_dest_red = '0;
  logic [7:0] in_dest_green = '0;
  logic [7:0] in_dest_blue = '0;
  logic [7:0] in_dest_alpha = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_write_enable;
  logic [23:0] out_pixel_index;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [7:0] out_alpha;
  logic cfg_write_enable = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic [31:0] cur_colour = '0;
  logic [12:0] cur_width = 13'd4096;
  logic [12:0] cur_height = 13'd4096;
  logic signed [12:0] cur_org_x = '0;
  logic signed [12:0] cur_org_y = '0;

  pixel_t pending_pixels[$];
  blend_t expected_blends[$];
  int pixels_queued = 0;
  int pixels_taken = 0;
  int writes_seen = 0;
  int skips_seen = 0;
  int mismatches = 0;
  int settings_used = 0;
  int cycle_count = 0;
  int send_gap = 0;
  int sink_gap = 0;
  int sink_hold = 0;
  bit idling_on = 1'b1;
  bit in_taken = 1'b0;
  bit hold_request = 1'b0;

  coverage_source_over_blend_core #(
    .MAX_DIM(DIM_CAP)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_coverage(in_coverage),
    .in_image_col(in_image_col),
    .in_image_row(in_image_row),
    .in_dest_red(in_dest_red),
    .in_dest_green(in_dest_green),
    .in_dest_blue(in_dest_blue),
    .in_dest_alpha(in_dest_alpha),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_write_enable(out_write_enable),
    .out_pixel_index(out_pixel_index),
    .out_red(out_red),
    .out_green(out_green),
    .out_blue(out_blue),
    .out_alpha(out_alpha),
    .cfg_write_enable(cfg_write_enable),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int frame_span(logic [12:0] dim);
    return (int'(dim) > DIM_CAP) ? DIM_CAP : int'(dim);
  endfunction

  function automatic int unsigned mix_channel(int unsigned src, int unsigned dst,
                                              int unsigned a, int unsigned d,
                                              int unsigned o);
    int unsigned q;
    q = (src * a + dst * d * (255 - a) / 255) / o;
    return (q > 255) ? 255 : q;
  endfunction

  function automatic blend_t blend_over(pixel_t p);
    blend_t r;
    int fx, fy, fw, fh;
    int unsigned a, o;
    r = '0;
    fw = frame_span(cur_width);
    fh = frame_span(cur_height);
    fx = int'(cur_org_x) + int'(p.col);
    fy = int'(cur_org_y) + int'(p.row);
    if (fx < 0 || fy < 0 || fx >= fw || fy >= fh || p.cov == 8'd0) return r;
    a = int'(p.cov) * (255 - int'(cur_colour[7:0])) / 255;
    if (a == 0) return r;
    o = a + int'(p.alpha) * (255 - a) / 255;
    if (o == 0) return r;
    r.we = 1'b1;
    r.index = 24'(fy * fw + fx);
    r.red = 8'(mix_channel(cur_colour[31:24], p.red, a, p.alpha, o));
    r.green = 8'(mix_channel(cur_colour[23:16], p.green, a, p.alpha, o));
    r.blue = 8'(mix_channel(cur_colour[15:8], p.blue, a, p.alpha, o));
    r.alpha = 8'(o);
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatches < 40) $display("mismatch: %s", msg);
    mismatches++;
  endtask

  task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h (result %0d)",
                                name, got, want, writes_seen + skips_seen));
  endtask

  // monitor: check results first, then predict for the transfer on the input
  always @(posedge clk) begin
    blend_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_blends.size() == 0) begin
          report_mismatch("result with no pixel outstanding");
        end else begin
          want = expected_blends.pop_front();
          compare_field("write_enable", out_write_enable, want.we);
          compare_field("pixel_index", out_pixel_index, want.index);
          compare_field("red", out_red, want.red);
          compare_field("green", out_green, want.green);
          compare_field("blue", out_blue, want.blue);
          compare_field("alpha", out_alpha, want.alpha);
          if (want.we) writes_seen++;
          else skips_seen++;
        end
      end
      if (in_valid && in_ready) begin
        expected_blends.push_back(blend_over(pixel_t'({in_coverage, in_image_col,
            in_image_row, in_dest_red, in_dest_green, in_dest_blue, in_dest_alpha})));
        pixels_taken++;
        in_taken = 1'b1;
      end
    end
  end

  // driver: hold the payload until the transfer, then advance
  always @(negedge clk) begin
    pixel_t p;
    if (rst_n && !(in_valid && !in_taken)) begin
      in_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_pixels.size() != 0) begin
        p = pending_pixels.pop_front();
        in_coverage <= p.cov;
        in_image_col <= p.col;
        in_image_row <= p.row;
        in_dest_red <= p.red;
        in_dest_green <= p.green;
        in_dest_blue <= p.blue;
        in_dest_alpha <= p.alpha;
        in_valid <= 1'b1;
        if (idling_on && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 4);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (sink_hold > 0) begin
        sink_hold--;
        out_ready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        sink_hold = LONG_HOLD;
        out_ready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (idling_on && $urandom_range(0, 4) == 0) sink_gap = $urandom_range(1, 4);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILURE");
      $finish;
    end
  end

  task automatic queue_pixel(pixel_t p);
    pending_pixels.push_back(p);
    pixels_queued++;
  endtask

  task automatic wait_drained();
    while (pixels_taken != pixels_queued || expected_blends.size() != 0) @(negedge clk);
  endtask

  task automatic set_config(logic [31:0] colour, logic [12:0] width, logic [12:0] height,
                            logic [12:0] org_x, logic [12:0] org_y);
    logic [CFG_DATA_W-1:0] vals[5];
    logic [CFG_IDX_W-1:0] regs[5];
    vals = '{colour, 32'(width), 32'(height), 32'(org_x), 32'(org_y)};
    regs = '{CFG_SOURCE_COLOR, CFG_FRAME_WIDTH, CFG_FRAME_HEIGHT, CFG_ORIGIN_X,
             CFG_ORIGIN_Y};
    for (int i = 0; i < 5; i++) begin
      cfg_write_enable <= 1'b1;
      cfg_index <= regs[i];
      cfg_data <= vals[i];
      @(negedge clk);
    end
    cfg_write_enable <= 1'b0;
    cur_colour = colour;
    cur_width = width;
    cur_height = height;
    cur_org_x = org_x;
    cur_org_y = org_y;
    settings_used++;
  endtask

  function automatic int pick_dim();
    case ($urandom_range(0, 9))
      0: return 1;
      1: return DIM_CAP;
      2: return $urandom_range(DIM_CAP + 1, 8191);
      3: return 0;
      4, 5: return $urandom_range(1, 64);
      default: return $urandom_range(1, DIM_CAP);
    endcase
  endfunction

  function automatic int pick_origin(int span);
    int o;
    case ($urandom_range(0, 7))
      0: o = -4096;
      1: o = 4095;
      2: o = int'($urandom_range(0, 8191)) - 4096;
      default: o = int'($urandom_range(0, span)) - int'($urandom_range(0, 64));
    endcase
    return (o > 4095) ? 4095 : o;
  endfunction

  task automatic random_setting();
    logic [31:0] colour;
    int w, h;
    colour = $urandom;
    case ($urandom_range(0, 5))
      0, 1: colour[7:0] = 8'h00;
      2: colour[7:0] = 8'hFF;
      default: ;
    endcase
    w = pick_dim();
    h = pick_dim();
    set_config(colour, 13'(w), 13'(h), 13'(pick_origin(frame_span(13'(w)))),
               13'(pick_origin(frame_span(13'(h)))));
  endtask

  // aimed pixels land inside the frame where the origin allows; the rest are plain noise
  task automatic queue_random_pixel(bit aim);
    pixel_t p;
    int fw, fh, c, r;
    p = {$urandom, $urandom};
    fw = frame_span(cur_width);
    fh = frame_span(cur_height);
    if (aim && fw > 0 && fh > 0) begin
      c = int'($urandom_range(0, fw - 1)) - int'(cur_org_x);
      r = int'($urandom_range(0, fh - 1)) - int'(cur_org_y);
      if (c >= 0 && c <= 4095) p.col = 12'(c);
      if (r >= 0 && r <= 4095) p.row = 12'(r);
      case ($urandom_range(0, 9))
        0: p.cov = 8'h00;
        1, 2: p.cov = 8'hFF;
        default: ;
      endcase
      case ($urandom_range(0, 9))
        0, 1: p.alpha = 8'h00;
        2, 3: p.alpha = 8'hFF;
        default: ;
      endcase
    end
    queue_pixel(p);
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: black, full frame, origin at zero
    queue_pixel('{8'd255, 12'd0, 12'd0, 8'd255, 8'd255, 8'd255, 8'd255});
    queue_pixel('{8'd0, 12'd10, 12'd10, 8'd1, 8'd2, 8'd3, 8'd4});
    queue_pixel('{8'd255, 12'd4095, 12'd4095, 8'd0, 8'd0, 8'd0, 8'd0});
    queue_pixel('{8'd128, 12'd100, 12'd7, 8'd12, 8'd34, 8'd56, 8'd200});
    wait_drained();

    // opaque white, oversized frame clamps to the maximum
    set_config(32'hFFFF_FF00, 13'd8191, 13'd8191, 13'd0, 13'd0);
    queue_pixel('{8'd1, 12'd3, 12'd3, 8'd255, 8'd255, 8'd255, 8'd1});
    queue_pixel('{8'd200, 12'd4095, 12'd4095, 8'd90, 8'd0, 8'd255, 8'd77});
    queue_pixel('{8'd255, 12'd1, 12'd2, 8'd17, 8'd170, 8'd85, 8'd0});
    wait_drained();

    // clip at the left, right and bottom edges of a small frame with a negative origin
    set_config(32'h1234_5680, 13'd100, 13'd50, -13'sd5, -13'sd3);
    queue_pixel('{8'd255, 12'd4, 12'd3, 8'd10, 8'd20, 8'd30, 8'd40});
    queue_pixel('{8'd255, 12'd5, 12'd3, 8'd10, 8'd20, 8'd30, 8'd40});
    queue_pixel('{8'd99, 12'd104, 12'd52, 8'd200, 8'd100, 8'd50, 8'd255});
    queue_pixel('{8'd255, 12'd105, 12'd10, 8'd10, 8'd20, 8'd30, 8'd40});
    queue_pixel('{8'd255, 12'd20, 12'd53, 8'd10, 8'd20, 8'd30, 8'd40});
    wait_drained();

    // fully transparent colour
    set_config(32'hAABB_CCFF, 13'd1, 13'd1, 13'd0, 13'd0);
    queue_pixel('{8'd255, 12'd0, 12'd0, 8'd5, 8'd6, 8'd7, 8'd8});
    queue_pixel('{8'd255, 12'd1, 12'd0, 8'd5, 8'd6, 8'd7, 8'd8});
    wait_drained();

    // zero-width frame clips everything
    set_config(32'h8040_2010, 13'd0, 13'd4096, 13'd0, 13'd0);
    queue_pixel('{8'd255, 12'd0, 12'd0, 8'd5, 8'd6, 8'd7, 8'd8});
    wait_drained();

    set_config(32'h8040_2010, 13'd4096, 13'd4096, 13'd4095, 13'd0);
    queue_pixel('{8'd255, 12'd0, 12'd0, 8'd5, 8'd6, 8'd7, 8'd8});
    queue_pixel('{8'd255, 12'd1, 12'd0, 8'd5, 8'd6, 8'd7, 8'd8});
    wait_drained();

    for (int ph = 0; ph < PHASES; ph++) begin
      random_setting();
      for (int i = 0; i < PHASE_PIXELS; i++) queue_random_pixel($urandom_range(0, 3) != 0);
      if (ph == 2) hold_request = 1'b1;
      wait_drained();
    end

    // final stretch at full rate
    idling_on = 1'b0;
    random_setting();
    for (int i = 0; i < PHASE_PIXELS; i++) queue_random_pixel($urandom_range(0, 3) != 0);
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (expected_blends.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_blends.size()));
    $display("blended %0d pixels over %0d colour and frame settings", pixels_taken,
             settings_used);
    $display("%0d pixel writes, %0d clipped or transparent, %0d mismatches", writes_seen,
             skips_seen, mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/cso_pkg.sv
design/cso_front.sv
design/cso_queue.sv
design/cso_div.sv
design/cso_blend.sv
design/coverage_source_over_blend_core.sv
verif/coverage_source_over_blend_core_tb.sv
